@@ rtl/core/dltq_pkg.sv @@
// Shared types and codes for the delta-list timer queue.
// Used by dltq_ctrl, dltq_dp and delta_list_timer_queue; no dependencies.
package dltq_pkg;

  localparam int MaxTimersDefault = 16;
  localparam int TimeBitsDefault  = 32;
  localparam int MaxExpiry        = 64;
  localparam int CntBits          = 7;
  localparam int InDataBits       = 72;
  localparam int OutDataBits      = 40;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD_START,
    CMD_INS_START,
    CMD_INS_STEP,
    CMD_INS_FIN,
    CMD_REM_START,
    CMD_UNL_STEP,
    CMD_UNL_FIN,
    CMD_ADV_START,
    CMD_ADV_TRIM,
    CMD_ADV_POP,
    CMD_SET_OVR,
    CMD_SNAP,
    CMD_EMIT
  } cmd_op_t;

  typedef enum logic [1:0] {
    EMIT_REJ,
    EMIT_DONE,
    EMIT_PEND,
    EMIT_FIN
  } emit_sel_t;

  typedef struct packed {
    cmd_op_t   op;
    emit_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       id_bad;
    logic       act_id;
    logic       ins_more;
    logic       unl_more;
    logic       list_ne;
    logic       adv_trim;
    logic       cnt_full;
    logic       rep_head;
    logic       pend_valid;
    logic       out_free;
  } status_t;

endpackage

@@ rtl/core/dltq_dp.sv @@
// Datapath of the timer queue: slot store, list walk registers, result register.
// Depends on dltq_pkg; driven by commands from dltq_ctrl.
module dltq_dp #(
  parameter int MAX_TIMERS = dltq_pkg::MaxTimersDefault,
  parameter int TIME_BITS  = dltq_pkg::TimeBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dltq_pkg::cmd_t                     cmd,
  output dltq_pkg::status_t                  status,
  input  logic [dltq_pkg::InDataBits-1:0]    in_data,
  input  logic [1:0]                         in_op,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dltq_pkg::OutDataBits-1:0]   out_data,
  output logic [1:0]                         out_kind,
  output logic                               out_last
);

  localparam int SW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int GW = $clog2(MAX_TIMERS + 1);
  localparam logic [63:0] TMAX = {64{1'b1}} >> (64 - TIME_BITS);

  typedef logic [SW-1:0]        slot_t;
  typedef logic [TIME_BITS-1:0] tm_t;

  tm_t   delta  [MAX_TIMERS];
  tm_t   period [MAX_TIMERS];
  logic  rep    [MAX_TIMERS];
  slot_t nxt    [MAX_TIMERS];
  logic  lok    [MAX_TIMERS];
  logic  act    [MAX_TIMERS];
  slot_t head;
  logic  nonempty;

  logic [1:0]  op_r;
  logic [3:0]  id_r;
  logic [31:0] per_in;
  logic        rep_in;
  logic [31:0] ela_in;

  slot_t cur, prev, ins_slot, pend_slot;
  logic  have, have_prev;
  tm_t   pend, rem;
  logic [GW-1:0] guard;
  logic [dltq_pkg::CntBits-1:0] cnt;
  logic  pend_valid, ovr;
  logic  snap_hn;
  logic [31:0] snap_nd;

  slot_t sl;
  logic  found;
  logic  [TIME_BITS:0] usum;
  logic  cur_hn;
  logic  [31:0] cur_nd;

  function automatic tm_t sat32(input logic [31:0] v);
    return (64'(v) > TMAX) ? {TIME_BITS{1'b1}} : TIME_BITS'(v);
  endfunction

  assign sl     = SW'(id_r);
  assign found  = nonempty && (cur == sl);
  assign usum   = {1'b0, delta[nxt[sl]]} + {1'b0, delta[sl]};
  assign cur_hn = nonempty;
  assign cur_nd = nonempty ? 32'(delta[head]) : 32'd0;

  always_comb begin
    status.op         = op_r;
    status.id_bad     = (32'(id_r) >= MAX_TIMERS);
    status.act_id     = act[sl];
    status.ins_more   = have && (32'(guard) < MAX_TIMERS) && (delta[cur] < pend);
    status.unl_more   = nonempty && (cur != sl) && (32'(guard) < MAX_TIMERS) && lok[cur];
    status.list_ne    = nonempty;
    status.adv_trim   = rem < delta[head];
    status.cnt_full   = (32'(cnt) == dltq_pkg::MaxExpiry);
    status.rep_head   = rep[head];
    status.pend_valid = pend_valid;
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        delta[i]  <= '0;
        period[i] <= '0;
        rep[i]    <= 1'b0;
        nxt[i]    <= '0;
        lok[i]    <= 1'b0;
        act[i]    <= 1'b0;
      end
      head       <= '0;
      nonempty   <= 1'b0;
      pend_valid <= 1'b0;
      ovr        <= 1'b0;
      cnt        <= '0;
      guard      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == dltq_pkg::CMD_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        dltq_pkg::CMD_LOAD: begin
          op_r   <= in_op;
          id_r   <= in_data[3:0];
          per_in <= in_data[35:4];
          rep_in <= in_data[36];
          ela_in <= in_data[68:37];
          ovr    <= 1'b0;
        end
        dltq_pkg::CMD_ADD_START: begin
          period[sl] <= sat32(per_in);
          rep[sl]    <= rep_in;
          act[sl]    <= 1'b1;
          ins_slot   <= sl;
        end
        dltq_pkg::CMD_INS_START: begin
          cur       <= head;
          have      <= nonempty;
          have_prev <= 1'b0;
          pend      <= period[ins_slot];
          guard     <= '0;
        end
        dltq_pkg::CMD_INS_STEP: begin
          pend      <= pend - delta[cur];
          prev      <= cur;
          have_prev <= 1'b1;
          have      <= lok[cur];
          cur       <= nxt[cur];
          guard     <= guard + 1'b1;
        end
        dltq_pkg::CMD_INS_FIN: begin
          delta[ins_slot] <= pend;
          lok[ins_slot]   <= have;
          nxt[ins_slot]   <= have ? cur : '0;
          if (have) delta[cur] <= delta[cur] - pend;
          if (have_prev) begin
            nxt[prev] <= ins_slot;
            lok[prev] <= 1'b1;
          end else begin
            head     <= ins_slot;
            nonempty <= 1'b1;
          end
        end
        dltq_pkg::CMD_REM_START: begin
          cur       <= head;
          have_prev <= 1'b0;
          guard     <= '0;
        end
        dltq_pkg::CMD_UNL_STEP: begin
          prev      <= cur;
          have_prev <= 1'b1;
          cur       <= nxt[cur];
          guard     <= guard + 1'b1;
        end
        dltq_pkg::CMD_UNL_FIN: begin
          if (found) begin
            if (lok[sl]) begin
              delta[nxt[sl]] <= usum[TIME_BITS] ? {TIME_BITS{1'b1}} : usum[TIME_BITS-1:0];
            end
            if (have_prev) begin
              nxt[prev] <= nxt[sl];
              lok[prev] <= lok[sl];
            end else if (lok[sl]) begin
              head <= nxt[sl];
            end else begin
              nonempty <= 1'b0;
              head     <= '0;
            end
            lok[sl]   <= 1'b0;
            nxt[sl]   <= '0;
            delta[sl] <= '0;
          end
          act[sl] <= 1'b0;
        end
        dltq_pkg::CMD_ADV_START: begin
          rem        <= sat32(ela_in);
          cnt        <= '0;
          pend_valid <= 1'b0;
        end
        dltq_pkg::CMD_ADV_TRIM: begin
          delta[head] <= delta[head] - rem;
        end
        dltq_pkg::CMD_ADV_POP: begin
          rem <= rem - delta[head];
          if (lok[head]) begin
            head <= nxt[head];
          end else begin
            nonempty <= 1'b0;
            head     <= '0;
          end
          lok[head]   <= 1'b0;
          nxt[head]   <= '0;
          delta[head] <= '0;
          if (!rep[head]) act[head] <= 1'b0;
          cnt       <= cnt + 1'b1;
          pend_slot <= head;
          ins_slot  <= head;
        end
        dltq_pkg::CMD_SET_OVR: begin
          ovr <= 1'b1;
        end
        dltq_pkg::CMD_SNAP: begin
          pend_valid <= 1'b1;
          snap_hn    <= cur_hn;
          snap_nd    <= cur_nd;
        end
        dltq_pkg::CMD_EMIT: begin
          unique case (cmd.sel)
            dltq_pkg::EMIT_REJ: begin
              out_kind <= dltq_pkg::KIND_REJECT;
              out_data <= {2'b00, 1'b0, cur_nd, cur_hn, id_r};
              out_last <= 1'b1;
            end
            dltq_pkg::EMIT_DONE: begin
              out_kind <= dltq_pkg::KIND_DONE;
              out_data <= {2'b00, ovr, cur_nd, cur_hn, id_r};
              out_last <= 1'b1;
            end
            dltq_pkg::EMIT_PEND: begin
              out_kind   <= dltq_pkg::KIND_FIRED;
              out_data   <= {2'b00, 1'b0, snap_nd, snap_hn, 4'(pend_slot)};
              out_last   <= 1'b0;
              pend_valid <= 1'b0;
            end
            dltq_pkg::EMIT_FIN: begin
              out_kind <= dltq_pkg::KIND_FIRED;
              out_data <= {2'b00, ovr, cur_nd, cur_hn, 4'(pend_slot)};
              out_last <= 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !nonempty |-> head == '0)
    else $error("head slot set on empty list");
  assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= dltq_pkg::MaxExpiry)
    else $error("expiry count beyond cap");
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == dltq_pkg::CMD_EMIT |-> status.out_free)
    else $error("result written over a pending transfer");

endmodule

@@ rtl/core/dltq_ctrl.sv @@
// Controller state machine of the timer queue: sequences add, remove and advance.
// Depends on dltq_pkg; drives dltq_dp through cmd_t and reads status_t.
module dltq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dltq_pkg::status_t status,
  output dltq_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RE,
    S_INS,
    S_INS_FIN,
    S_UNL,
    S_ADV,
    S_SNAP,
    S_EMIT
  } state_t;

  state_t               state;
  dltq_pkg::emit_sel_t  emit_sel;
  logic                 ins_adv;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op  = dltq_pkg::CMD_NONE;
    cmd.sel = emit_sel;
    unique case (state)
      S_IDLE:    if (in_valid) cmd.op = dltq_pkg::CMD_LOAD;
      S_DECODE: begin
        case (status.op)
          dltq_pkg::OP_ADD:
            if (!(status.id_bad || status.act_id)) cmd.op = dltq_pkg::CMD_ADD_START;
          dltq_pkg::OP_REMOVE:
            if (!(status.id_bad || !status.act_id)) cmd.op = dltq_pkg::CMD_REM_START;
          dltq_pkg::OP_ADVANCE: cmd.op = dltq_pkg::CMD_ADV_START;
          default: ;
        endcase
      end
      S_RE:      cmd.op = dltq_pkg::CMD_INS_START;
      S_INS:     if (status.ins_more) cmd.op = dltq_pkg::CMD_INS_STEP;
      S_INS_FIN: cmd.op = dltq_pkg::CMD_INS_FIN;
      S_UNL:     cmd.op = status.unl_more ? dltq_pkg::CMD_UNL_STEP : dltq_pkg::CMD_UNL_FIN;
      S_ADV: begin
        if (status.list_ne) begin
          if (status.adv_trim) cmd.op = dltq_pkg::CMD_ADV_TRIM;
          else if (status.cnt_full) cmd.op = dltq_pkg::CMD_SET_OVR;
          else if (!status.pend_valid) cmd.op = dltq_pkg::CMD_ADV_POP;
        end
      end
      S_SNAP:    cmd.op = dltq_pkg::CMD_SNAP;
      S_EMIT:    if (status.out_free) cmd.op = dltq_pkg::CMD_EMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      emit_sel <= dltq_pkg::EMIT_DONE;
      ins_adv  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          case (status.op)
            dltq_pkg::OP_ADD: begin
              if (status.id_bad || status.act_id) begin
                emit_sel <= dltq_pkg::EMIT_REJ;
                state    <= S_EMIT;
              end else begin
                ins_adv <= 1'b0;
                state   <= S_RE;
              end
            end
            dltq_pkg::OP_REMOVE: begin
              if (status.id_bad || !status.act_id) begin
                emit_sel <= dltq_pkg::EMIT_REJ;
                state    <= S_EMIT;
              end else begin
                state <= S_UNL;
              end
            end
            dltq_pkg::OP_ADVANCE: state <= S_ADV;
            default: begin
              emit_sel <= dltq_pkg::EMIT_REJ;
              state    <= S_EMIT;
            end
          endcase
        end
        S_RE:  state <= S_INS;
        S_INS: if (!status.ins_more) state <= S_INS_FIN;
        S_INS_FIN: begin
          if (ins_adv) begin
            state <= S_SNAP;
          end else begin
            emit_sel <= dltq_pkg::EMIT_DONE;
            state    <= S_EMIT;
          end
        end
        S_UNL: begin
          if (!status.unl_more) begin
            emit_sel <= dltq_pkg::EMIT_DONE;
            state    <= S_EMIT;
          end
        end
        S_ADV: begin
          if (!status.list_ne || status.adv_trim || status.cnt_full) begin
            emit_sel <= status.pend_valid ? dltq_pkg::EMIT_FIN : dltq_pkg::EMIT_DONE;
            state    <= S_EMIT;
          end else if (status.pend_valid) begin
            emit_sel <= dltq_pkg::EMIT_PEND;
            state    <= S_EMIT;
          end else if (status.rep_head) begin
            ins_adv <= 1'b1;
            state   <= S_RE;
          end else begin
            state <= S_SNAP;
          end
        end
        S_SNAP: state <= S_ADV;
        S_EMIT: begin
          if (status.out_free) begin
            state <= (emit_sel == dltq_pkg::EMIT_PEND) ? S_ADV : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !status.out_free) |=> state == S_EMIT)
    else $error("left emit state while output was full");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cmd.op == dltq_pkg::CMD_NONE || cmd.op == dltq_pkg::CMD_LOAD)
    else $error("datapath command while idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SNAP) |=> state == S_ADV)
    else $error("snapshot not followed by advance step");

endmodule

@@ rtl/core/delta_list_timer_queue.sv @@
// Delta-list timer queue: top level joining controller and datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_dp.
//
// Requests enter on the s_axis channel (tuser = op: add, remove, advance) and
// results leave on m_axis (tuser = kind, tlast = final result of a request).
// Add and remove give one result; an advance gives one result per expiry, at
// most 64, or a single done result when nothing expires.
// One request is handled at a time. Add walks the sorted list one entry per
// cycle to its insert point, and remove walks the list to the slot. An advance
// pops its expiries one at a time and runs the insert walk for each repeating
// timer that re-arms. The list walk is the limiting loop for an add or remove,
// and the work of an advance grows with the number of expiries it reports.
// Results pass through an output register; when m_axis_tready is low the
// sequencer holds its next result until the pending one is taken, yet a new
// request may be taken while a final result waits. Reset (rst, synchronous)
// clears all slots and the list; the block is ready in the cycle after reset.
module delta_list_timer_queue #(
  parameter int MAX_TIMERS = dltq_pkg::MaxTimersDefault,
  parameter int TIME_BITS  = dltq_pkg::TimeBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // timer_id[3:0], period_ms[35:4], repeat_req[36], elapsed_ms[68:37], zero pad
  input  logic [dltq_pkg::InDataBits-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // fired_id[3:0], has_next[4], next_deadline_ms[36:5], overrun[37], zero pad
  output logic [dltq_pkg::OutDataBits-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  dltq_pkg::cmd_t    cmd;
  dltq_pkg::status_t status;

  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dltq_dp #(
    .MAX_TIMERS (MAX_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for delta_list_timer_queue: randomized add, remove and
// advance requests on s_axis, results on m_axis checked against an in-bench model.
// Depends on dltq_pkg and the delta_list_timer_queue RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [31:0] period;
    logic        rep;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic        has_next;
    logic [31:0] deadline;
    logic        ovr;
    logic        last;
  } evt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [dltq_pkg::InDataBits-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [dltq_pkg::OutDataBits-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  delta_list_timer_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #6 clk = ~clk;

  // timer list shadow
  logic [31:0] dl[NSLOT];
  logic [31:0] per[NSLOT];
  logic        rpt[NSLOT];
  logic [3:0]  nxt[NSLOT];
  logic        lnk[NSLOT];
  logic        act[NSLOT];
  logic [3:0]  head;
  logic        nonempty;

  req_t req_q[$];
  evt_t expected_q[$];
  int   errors = 0;
  bit   sender_hold = 0;
  bit   quiet = 0;
  int   stall_long = 0;

  function automatic evt_t make_evt(logic [1:0] k, logic [3:0] id, logic o, logic l);
    evt_t e;
    e.kind = k;
    e.id = id;
    e.has_next = nonempty;
    e.deadline = nonempty ? dl[head] : 32'd0;
    e.ovr = o;
    e.last = l;
    return e;
  endfunction

  function automatic void insert_timer(logic [3:0] s, logic [31:0] pend);
    logic [3:0] cur, prev;
    bit have, have_prev;
    int guard;
    cur = head; prev = 4'd0; have = nonempty; have_prev = 1'b0; guard = 0;
    while (have && guard < NSLOT && dl[cur] < pend) begin
      pend -= dl[cur];
      prev = cur;
      have_prev = 1'b1;
      have = lnk[cur];
      cur = nxt[cur];
      guard++;
    end
    dl[s] = pend;
    lnk[s] = have;
    nxt[s] = have ? cur : 4'd0;
    if (have) dl[cur] -= pend;
    if (have_prev) begin
      nxt[prev] = s;
      lnk[prev] = 1'b1;
    end else begin
      head = s;
      nonempty = 1'b1;
    end
  endfunction

  function automatic void unlink_timer(logic [3:0] s);
    logic [3:0] cur, prev;
    bit have_prev;
    int guard;
    logic [32:0] sum;
    cur = head; prev = 4'd0; have_prev = 1'b0; guard = 0;
    if (!nonempty) return;
    while (cur != s && guard < NSLOT) begin
      if (!lnk[cur]) return;
      prev = cur;
      have_prev = 1'b1;
      cur = nxt[cur];
      guard++;
    end
    if (cur != s) return;
    if (lnk[s]) begin
      sum = {1'b0, dl[nxt[s]]} + {1'b0, dl[s]};
      dl[nxt[s]] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (have_prev) begin
      nxt[prev] = nxt[s];
      lnk[prev] = lnk[s];
    end else if (lnk[s]) begin
      head = nxt[s];
    end else begin
      nonempty = 1'b0;
      head = 4'd0;
    end
    lnk[s] = 1'b0;
    nxt[s] = 4'd0;
    dl[s] = 32'd0;
  endfunction

  function automatic void predict_results(req_t r);
    logic [31:0] rem;
    logic [3:0] h;
    int n;
    bit ovr;
    evt_t ev[$];
    rem = r.elapsed; n = 0; ovr = 1'b0;
    if (r.op == dltq_pkg::OP_ADD) begin
      if (act[r.id]) begin
        expected_q.push_back(make_evt(dltq_pkg::KIND_REJECT, r.id, 1'b0, 1'b1));
        return;
      end
      per[r.id] = r.period;
      rpt[r.id] = r.rep;
      act[r.id] = 1'b1;
      insert_timer(r.id, r.period);
      expected_q.push_back(make_evt(dltq_pkg::KIND_DONE, r.id, 1'b0, 1'b1));
      return;
    end
    if (r.op == dltq_pkg::OP_REMOVE) begin
      if (!act[r.id]) begin
        expected_q.push_back(make_evt(dltq_pkg::KIND_REJECT, r.id, 1'b0, 1'b1));
        return;
      end
      unlink_timer(r.id);
      act[r.id] = 1'b0;
      expected_q.push_back(make_evt(dltq_pkg::KIND_DONE, r.id, 1'b0, 1'b1));
      return;
    end
    if (r.op != dltq_pkg::OP_ADVANCE) begin
      expected_q.push_back(make_evt(dltq_pkg::KIND_REJECT, r.id, 1'b0, 1'b1));
      return;
    end
    while (nonempty) begin
      h = head;
      if (rem < dl[h]) begin
        dl[h] -= rem;
        break;
      end
      if (n == dltq_pkg::MaxExpiry) begin
        ovr = 1'b1;
        break;
      end
      rem -= dl[h];
      if (lnk[h]) head = nxt[h];
      else begin
        nonempty = 1'b0;
        head = 4'd0;
      end
      lnk[h] = 1'b0;
      nxt[h] = 4'd0;
      dl[h] = 32'd0;
      if (rpt[h]) insert_timer(h, per[h]);
      else act[h] = 1'b0;
      ev.push_back(make_evt(dltq_pkg::KIND_FIRED, h, 1'b0, 1'b0));
      n++;
    end
    if (n == 0) begin
      expected_q.push_back(make_evt(dltq_pkg::KIND_DONE, r.id, ovr, 1'b1));
      return;
    end
    ev[n-1] = make_evt(dltq_pkg::KIND_FIRED, ev[n-1].id, ovr, 1'b1);
    foreach (ev[i]) expected_q.push_back(ev[i]);
  endfunction

  function automatic req_t mk(logic [1:0] op, logic [3:0] id, logic [31:0] p,
                              logic rep, logic [31:0] e);
    req_t r;
    r.op = op; r.id = id; r.period = p; r.rep = rep; r.elapsed = e;
    return r;
  endfunction

  function automatic logic [31:0] rnd_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  // driver
  int  s_gap = 0;
  bit  s_busy = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_results(req_q.pop_front());
        s_busy = 0;
      end
      if (s_busy) begin
      end else if (s_gap > 0) begin
        s_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        s_gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0 && !sender_hold) begin
        s_axis_tdata <= {3'b0, req_q[0].elapsed, req_q[0].rep, req_q[0].period, req_q[0].id};
        s_axis_tuser <= req_q[0].op;
        s_axis_tvalid <= 1'b1;
        s_busy = 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int m_gap = 0;
  always @(posedge clk) begin
    evt_t got, exp_e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.id = m_axis_tdata[3:0];
        got.has_next = m_axis_tdata[4];
        got.deadline = m_axis_tdata[36:5];
        got.ovr = m_axis_tdata[37];
        got.last = m_axis_tlast;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_e = expected_q.pop_front();
          if (got !== exp_e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp_e, got);
          end
        end
      end
      if (stall_long > 0) begin
        stall_long--;
        m_axis_tready <= 1'b0;
      end else if (m_gap > 0) begin
        m_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_gap = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drain();
    while (req_q.size() > 0 || s_busy || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    head = 4'd0;
    nonempty = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      dl[i] = 32'd0;
      per[i] = 32'd0;
      rpt[i] = 1'b0;
      nxt[i] = 4'd0;
      lnk[i] = 1'b0;
      act[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed
    req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd5));
    req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'd3, 32'd0, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd0, 32'd10, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd0, 32'd10, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd15, 32'd10, 1'b1, 32'hFFFF_FFFF));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd5, 32'hFFFF_FFFF, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd6, 32'd3, 1'b1, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'd0, 32'd0, 1'b0, 32'd0));
    req_q.push_back(mk(2'd3, 4'd9, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd25));
    req_q.push_back(mk(dltq_pkg::OP_ADD, 4'd7, 32'd0, 1'b1, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd1));
    req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'd7, 32'd0, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'd6, 32'd0, 1'b0, 32'd0));
    req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'd15, 32'd0, 1'b0, 32'd0));
    wait_drain();
    // long receiver hold while requests keep coming
    stall_long = 300;
    for (int i = 0; i < 240; i++) begin
      int c;
      c = $urandom_range(0, 19);
      if (i == 120) begin
        wait_drain();
        sender_hold = 1;
        repeat (20) @(posedge clk);
        sender_hold = 0;
      end
      if (i == 200) quiet = 1;
      if (c < 8)
        req_q.push_back(mk(dltq_pkg::OP_ADD, 4'($urandom_range(0, 15)), rnd_time(),
                           1'($urandom_range(0, 1)), $urandom()));
      else if (c < 12)
        req_q.push_back(mk(dltq_pkg::OP_REMOVE, 4'($urandom_range(0, 15)), $urandom(),
                           1'($urandom_range(0, 1)), $urandom()));
      else if (c < 19)
        req_q.push_back(mk(dltq_pkg::OP_ADVANCE, 4'($urandom_range(0, 15)), $urandom(),
                           1'($urandom_range(0, 1)), rnd_time()));
      else
        req_q.push_back(mk(2'd3, 4'($urandom_range(0, 15)), $urandom(),
                           1'($urandom_range(0, 1)), $urandom()));
      if (req_q.size() > 8) wait (req_q.size() <= 2);
    end
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
